@@ design/tprt_pkg.sv @@
// Shared types, widths and helpers for the touch press/release tracker.
// No dependencies; imported by tprt_scale, touch_press_release_tracker_unit and tb.
package tprt_pkg;

    // Field widths
    localparam int RAW_BITS      = 10;
    localparam int PIXEL_BITS    = 12;
    localparam int SIZE_BITS     = 13;
    localparam int PRESS_BITS    = 16;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Derived widths
    localparam int CNT_BITS      = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
    localparam int PROD_BITS     = RAW_BITS + PIXEL_BITS;
    localparam int IN_DATA_BITS  = ((2 * RAW_BITS + PRESS_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * PIXEL_BITS + 7) / 8) * 8;

    // Cycles from start of a mapping to its done strobe
    localparam int MAP_LATENCY   = 2 * PIXEL_BITS + 1;

    // Register reset values
    localparam logic [SIZE_BITS-1:0]  WIDTH_RST   = SIZE_BITS'(240);
    localparam logic [SIZE_BITS-1:0]  HEIGHT_RST  = SIZE_BITS'(320);
    localparam logic [PRESS_BITS-1:0] P_LOW_RST   = PRESS_BITS'(10);
    localparam logic [PRESS_BITS-1:0] P_HIGH_RST  = PRESS_BITS'(1000);
    localparam logic [RAW_BITS-1:0]   X_BEGIN_RST = RAW_BITS'(120);
    localparam logic [RAW_BITS-1:0]   X_END_RST   = RAW_BITS'(900);
    localparam logic [RAW_BITS-1:0]   Y_BEGIN_RST = RAW_BITS'(70);
    localparam logic [RAW_BITS-1:0]   Y_END_RST   = RAW_BITS'(920);

    typedef enum logic [OP_BITS-1:0] {
        OP_SAMPLE       = 2'd0,
        OP_TAKE_PRESS   = 2'd1,
        OP_TAKE_RELEASE = 2'd2,
        OP_READ_POS     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_PRESSURE_LOW  = 3'd2,
        REG_PRESSURE_HIGH = 3'd3,
        REG_X_BEGIN       = 3'd4,
        REG_X_END         = 3'd5,
        REG_Y_BEGIN       = 3'd6,
        REG_Y_END         = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } t_scl_state;

    typedef enum logic {
        ST_IDLE,
        ST_MAP
    } t_state;

    // Request to one axis scaler
    typedef struct packed {
        logic                  start;
        logic [RAW_BITS-1:0]   raw;
        logic [RAW_BITS-1:0]   lo;
        logic [RAW_BITS-1:0]   hi;
        logic [PIXEL_BITS-1:0] span;
    } t_scl_req;

    // Answer of one axis scaler
    typedef struct packed {
        logic                  done;
        logic [PIXEL_BITS-1:0] value;
    } t_scl_rsp;

    // Largest pixel index for a screen size: zero acts as one, large sizes saturate
    function automatic logic [PIXEL_BITS-1:0] span_of(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] dec;
        dec = size - SIZE_BITS'(1);
        if (size == '0) begin
            span_of = '0;
        end else if (32'(size) > (32'd1 << PIXEL_BITS)) begin
            span_of = '1;
        end else begin
            span_of = PIXEL_BITS'(dec);
        end
    endfunction

endpackage

@@ design/touch_press_release_tracker_unit.sv @@
// Touch press/release tracker: sample filtering, event latching and read answers.
// Depends on tprt_pkg and two tprt_scale instances for the x and y mapping.
//
// Usage:
//   Input words arrive on the s_axis channel: tuser carries the op code, tdata the
//   raw x, raw y and pressure. A sample op gives no output word; take-press,
//   take-release and read-position ops each give one output word on m_axis
//   (tuser = found, tdata = column and row).
//   Configuration registers are written through the cfg channel (index, data),
//   which is always ready; write them only while the block is idle.
// Timing and throughput:
//   A read op is answered in the cycle after it is accepted, and the next word can
//   be taken in the following cycle, so reads run at one word per cycle while the
//   receiver takes each answer. A sample inside the pressure bounds holds off the
//   next word until both axes are mapped: each axis runs a 12-step serial multiply
//   and a 12-step restoring divide, one bit per cycle, plus load and finish steps.
//   A sample outside the bounds does not hold off the next word.
// Reset and stall:
//   Reset restores the default calibration and clears pressed and both events.
//   The answer sits in an output register; while the receiver stalls with a
//   word held there, no new word is taken on the input side.
module touch_press_release_tracker_unit
    import tprt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,   // raw_x, raw_y, raw_pressure, zero pad
    input  logic [OP_BITS-1:0]       i_s_axis_tuser,   // op
    // Output stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,   // x_out, y_out
    output logic                     o_m_axis_tuser,   // found
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration
    logic [SIZE_BITS-1:0]  r_width, n_width;
    logic [SIZE_BITS-1:0]  r_height, n_height;
    logic [PRESS_BITS-1:0] r_p_low, n_p_low;
    logic [PRESS_BITS-1:0] r_p_high, n_p_high;
    logic [RAW_BITS-1:0]   r_x_begin, n_x_begin;
    logic [RAW_BITS-1:0]   r_x_end, n_x_end;
    logic [RAW_BITS-1:0]   r_y_begin, n_y_begin;
    logic [RAW_BITS-1:0]   r_y_end, n_y_end;

    // Tracking state
    t_state                r_state, n_state;
    logic                  r_pressed, n_pressed;
    logic                  r_press_pend, n_press_pend;
    logic                  r_rel_pend, n_rel_pend;
    logic [PIXEL_BITS-1:0] r_press_col, n_press_col;
    logic [PIXEL_BITS-1:0] r_press_row, n_press_row;
    logic [PIXEL_BITS-1:0] r_rel_col, n_rel_col;
    logic [PIXEL_BITS-1:0] r_rel_row, n_rel_row;
    logic [PIXEL_BITS-1:0] r_cur_col, n_cur_col;
    logic [PIXEL_BITS-1:0] r_cur_row, n_cur_row;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found, n_out_found;
    logic [PIXEL_BITS-1:0] r_out_x, n_out_x;
    logic [PIXEL_BITS-1:0] r_out_y, n_out_y;

    // Input word fields
    t_op                   in_op;
    logic [RAW_BITS-1:0]   in_x;
    logic [RAW_BITS-1:0]   in_y;
    logic [PRESS_BITS-1:0] in_pz;

    logic                  s_accept;
    logic                  w_touch;
    logic [PIXEL_BITS-1:0] w_span_x;
    logic [PIXEL_BITS-1:0] w_span_y;
    logic                  w_y_empty;
    logic [PIXEL_BITS-1:0] w_cy;
    t_scl_req              req_x, req_y;
    t_scl_rsp              rsp_x, rsp_y;

    // Unpack the input word
    assign in_op = t_op'(i_s_axis_tuser);
    assign in_x  = i_s_axis_tdata[RAW_BITS-1:0];
    assign in_y  = i_s_axis_tdata[2*RAW_BITS-1:RAW_BITS];
    assign in_pz = i_s_axis_tdata[2*RAW_BITS+PRESS_BITS-1:2*RAW_BITS];

    // Handshakes
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Touch test and axis spans
    assign w_touch   = (r_p_low <= in_pz) && (in_pz <= r_p_high);
    assign w_span_x  = span_of(r_width);
    assign w_span_y  = span_of(r_height);
    assign w_y_empty = (r_y_begin >= r_y_end);
    assign w_cy      = w_y_empty ? '0 : (w_span_y - rsp_y.value);

    // Launch both axis scalers on an accepted touch sample
    always_comb begin
        req_x.start = s_accept && (in_op == OP_SAMPLE) && w_touch;
        req_x.raw   = in_x;
        req_x.lo    = r_x_begin;
        req_x.hi    = r_x_end;
        req_x.span  = w_span_x;
        req_y.start = req_x.start;
        req_y.raw   = in_y;
        req_y.lo    = r_y_begin;
        req_y.hi    = r_y_end;
        req_y.span  = w_span_y;
    end

    tprt_scale u_scale_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_x),
        .o_rsp   (rsp_x)
    );

    tprt_scale u_scale_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_y),
        .o_rsp   (rsp_y)
    );

    // Next state: config writes, ops, mapping completion, output drain
    always_comb begin
        n_width      = r_width;
        n_height     = r_height;
        n_p_low      = r_p_low;
        n_p_high     = r_p_high;
        n_x_begin    = r_x_begin;
        n_x_end      = r_x_end;
        n_y_begin    = r_y_begin;
        n_y_end      = r_y_end;
        n_state      = r_state;
        n_pressed    = r_pressed;
        n_press_pend = r_press_pend;
        n_rel_pend   = r_rel_pend;
        n_press_col  = r_press_col;
        n_press_row  = r_press_row;
        n_rel_col    = r_rel_col;
        n_rel_row    = r_rel_row;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;

        // Drop the output word once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Apply a configuration write
        if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SCREEN_WIDTH:  n_width   = i_cfg_data[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: n_height  = i_cfg_data[SIZE_BITS-1:0];
                REG_PRESSURE_LOW:  n_p_low   = i_cfg_data[PRESS_BITS-1:0];
                REG_PRESSURE_HIGH: n_p_high  = i_cfg_data[PRESS_BITS-1:0];
                REG_X_BEGIN:       n_x_begin = i_cfg_data[RAW_BITS-1:0];
                REG_X_END:         n_x_end   = i_cfg_data[RAW_BITS-1:0];
                REG_Y_BEGIN:       n_y_begin = i_cfg_data[RAW_BITS-1:0];
                REG_Y_END:         n_y_end   = i_cfg_data[RAW_BITS-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_op)
                        OP_SAMPLE: begin
                            if (w_touch) begin
                                n_state = ST_MAP;
                            end else if (r_pressed) begin
                                // Lift: latch release at the press point
                                n_pressed  = 1'b0;
                                n_rel_pend = 1'b1;
                                n_rel_col  = r_press_col;
                                n_rel_row  = r_press_row;
                            end
                        end
                        OP_TAKE_PRESS: begin
                            n_out_valid  = 1'b1;
                            n_out_found  = r_press_pend;
                            n_out_x      = r_press_pend ? r_press_col : '0;
                            n_out_y      = r_press_pend ? r_press_row : '0;
                            n_press_pend = 1'b0;
                        end
                        OP_TAKE_RELEASE: begin
                            n_out_valid = 1'b1;
                            n_out_found = r_rel_pend;
                            n_out_x     = r_rel_pend ? r_rel_col : '0;
                            n_out_y     = r_rel_pend ? r_rel_row : '0;
                            n_rel_pend  = 1'b0;
                        end
                        OP_READ_POS: begin
                            n_out_valid = 1'b1;
                            n_out_found = r_pressed;
                            n_out_x     = r_pressed ? r_cur_col : '0;
                            n_out_y     = r_pressed ? r_cur_row : '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAP: begin
                if (rsp_x.done) begin
                    n_state   = ST_IDLE;
                    n_cur_col = rsp_x.value;
                    n_cur_row = w_cy;
                    if (r_pressed) begin
                        // Touch continues: clear both events
                        n_press_pend = 1'b0;
                        n_rel_pend   = 1'b0;
                    end else begin
                        // New touch: latch press event
                        n_pressed    = 1'b1;
                        n_press_pend = 1'b1;
                        n_press_col  = rsp_x.value;
                        n_press_row  = w_cy;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RST;
            r_height     <= HEIGHT_RST;
            r_p_low      <= P_LOW_RST;
            r_p_high     <= P_HIGH_RST;
            r_x_begin    <= X_BEGIN_RST;
            r_x_end      <= X_END_RST;
            r_y_begin    <= Y_BEGIN_RST;
            r_y_end      <= Y_END_RST;
            r_state      <= ST_IDLE;
            r_pressed    <= 1'b0;
            r_press_pend <= 1'b0;
            r_rel_pend   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_width      <= n_width;
            r_height     <= n_height;
            r_p_low      <= n_p_low;
            r_p_high     <= n_p_high;
            r_x_begin    <= n_x_begin;
            r_x_end      <= n_x_end;
            r_y_begin    <= n_y_begin;
            r_y_end      <= n_y_end;
            r_state      <= n_state;
            r_pressed    <= n_pressed;
            r_press_pend <= n_press_pend;
            r_rel_pend   <= n_rel_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // Coordinate and output payload registers
    always_ff @(posedge i_clk) begin
        r_press_col <= n_press_col;
        r_press_row <= n_press_row;
        r_rel_col   <= n_rel_col;
        r_rel_row   <= n_rel_row;
        r_cur_col   <= n_cur_col;
        r_cur_row   <= n_cur_row;
        r_out_found <= n_out_found;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
    end

    // Drive the output word
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_BITS'({r_out_y, r_out_x});
    assign o_m_axis_tuser  = r_out_found;

    // Both axes finish in the same cycle
    a_axes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_x.done == rsp_y.done)
        else $error("axis scalers out of step");

    // A touch sample completes after the fixed serial latency
    a_map_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_x.start |-> ##MAP_LATENCY rsp_x.done)
        else $error("mapping did not finish on time");

    // Every read op leaves an answer in the output register
    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_op != OP_SAMPLE) |=> o_m_axis_tvalid)
        else $error("read op produced no answer");

    // A miss carries zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_x == '0 && r_out_y == '0))
        else $error("miss with nonzero coordinates");

endmodule

@@ design/tprt_scale.sv @@
// One axis scaler: clamps a raw reading to its window and computes
// offset * span / window_size with a bit-serial multiply and restoring divide. Uses tprt_pkg.
module tprt_scale
    import tprt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_scl_req i_req,
    output t_scl_rsp o_rsp
);

    t_scl_state            r_state, n_state;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [RAW_BITS-1:0]   r_off, n_off;
    logic [RAW_BITS-1:0]   r_div, n_div;
    logic [PIXEL_BITS-1:0] r_span, n_span;
    logic [PROD_BITS-1:0]  r_acc, n_acc;
    logic                  r_empty, n_empty;

    logic [RAW_BITS-1:0]   w_clamped;
    logic [RAW_BITS:0]     w_trial;
    logic [RAW_BITS:0]     w_diff;

    // Clamp the raw reading into the window
    always_comb begin
        if (i_req.raw < i_req.lo) begin
            w_clamped = i_req.lo;
        end else if (i_req.raw > i_req.hi) begin
            w_clamped = i_req.hi;
        end else begin
            w_clamped = i_req.raw;
        end
    end

    // Partial remainder with the next dividend bit shifted in
    assign w_trial = {r_acc[PROD_BITS-1:PIXEL_BITS], r_acc[PIXEL_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    // Sequence: load, multiply one span bit a cycle, divide one quotient bit a cycle
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_off       = r_off;
        n_div       = r_div;
        n_span      = r_span;
        n_acc       = r_acc;
        n_empty     = r_empty;
        o_rsp.done  = 1'b0;
        o_rsp.value = r_empty ? '0 : r_acc[PIXEL_BITS-1:0];

        unique case (r_state)
            SC_IDLE: begin
                if (i_req.start) begin
                    n_off   = w_clamped - i_req.lo;
                    n_div   = i_req.hi - i_req.lo;
                    n_span  = i_req.span;
                    n_empty = (i_req.lo >= i_req.hi);
                    n_acc   = '0;
                    n_cnt   = CNT_BITS'(PIXEL_BITS - 1);
                    n_state = SC_MUL;
                end
            end
            SC_MUL: begin
                n_acc  = {r_acc[PROD_BITS-2:0], 1'b0}
                       + (r_span[PIXEL_BITS-1] ? PROD_BITS'(r_off) : '0);
                n_span = {r_span[PIXEL_BITS-2:0], 1'b0};
                n_cnt  = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    n_cnt   = CNT_BITS'(PIXEL_BITS - 1);
                    n_state = SC_DIV;
                end
            end
            SC_DIV: begin
                if (w_trial >= {1'b0, r_div}) begin
                    n_acc = {w_diff[RAW_BITS-1:0], r_acc[PIXEL_BITS-2:0], 1'b1};
                end else begin
                    n_acc = {w_trial[RAW_BITS-1:0], r_acc[PIXEL_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    n_state = SC_DONE;
                end
            end
            SC_DONE: begin
                o_rsp.done = 1'b1;
                n_state    = SC_IDLE;
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_off   <= n_off;
        r_div   <= n_div;
        r_span  <= n_span;
        r_acc   <= n_acc;
        r_empty <= n_empty;
    end

endmodule

@@ verif/tb.sv @@
// Testbench for touch_press_release_tracker_unit: directed and random words on the
// input stream, each answer checked against a local model of the tracker state.
// Depends on tprt_pkg for widths, op codes and register indexes.
module tb;
    import tprt_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = MAP_LATENCY + 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        logic                  found;
        logic [PIXEL_BITS-1:0] col;
        logic [PIXEL_BITS-1:0] row;
    } t_answer;

    // DUT inputs, all known from time zero
    logic                     i_clk     = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_valid   = 1'b0;
    logic [IN_DATA_BITS-1:0]  s_data    = '0;
    logic [OP_BITS-1:0]       s_user    = '0;
    logic                     m_ready   = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    logic                     o_s_axis_tready;
    logic                     o_m_axis_tvalid;
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic                     o_m_axis_tuser;
    logic                     o_cfg_ready;

    // Test control
    int      snd_idle_pct = 15;
    int      rcv_idle_pct = 48;
    int      err_cnt      = 0;
    int      words_sent   = 0;
    int      cycle_cnt    = 0;
    int      hold_left    = 0;
    logic    hold_req     = 1'b0;
    logic    hold_ack     = 1'b0;
    t_answer pending_answers[$];

    // Model copy of calibration and tracker state
    logic [SIZE_BITS-1:0]  cal_width, cal_height;
    logic [PRESS_BITS-1:0] cal_p_low, cal_p_high;
    logic [RAW_BITS-1:0]   cal_x_begin, cal_x_end, cal_y_begin, cal_y_end;
    logic                  is_down, press_evt, rel_evt;
    logic [PIXEL_BITS-1:0] press_col, press_row, rel_col, rel_row, cur_col, cur_row;

    touch_press_release_tracker_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- model

    // Largest pixel index for a screen size: zero counts as one, oversize saturates
    function automatic logic [PIXEL_BITS-1:0] max_index(input logic [SIZE_BITS-1:0] size);
        int unsigned s;
        s = 32'(size);
        if (s == 0) s = 1;
        if (s > (1 << PIXEL_BITS)) s = 1 << PIXEL_BITS;
        return PIXEL_BITS'(s - 1);
    endfunction

    // Clamp raw into the window and scale it onto 0..span, truncating
    function automatic logic [PIXEL_BITS-1:0] map_axis(input logic [RAW_BITS-1:0] raw, lo, hi,
                                                       input logic [PIXEL_BITS-1:0] span);
        longint unsigned r, prod;
        if (lo >= hi) return '0;
        r = 64'(raw);
        if (r < lo) r = 64'(lo);
        if (r > hi) r = 64'(hi);
        prod = (r - lo) * span;
        return PIXEL_BITS'(prod / (hi - lo));
    endfunction

    task automatic reset_tracker();
        cal_width   = WIDTH_RST;
        cal_height  = HEIGHT_RST;
        cal_p_low   = P_LOW_RST;
        cal_p_high  = P_HIGH_RST;
        cal_x_begin = X_BEGIN_RST;
        cal_x_end   = X_END_RST;
        cal_y_begin = Y_BEGIN_RST;
        cal_y_end   = Y_END_RST;
        is_down     = 1'b0;
        press_evt   = 1'b0;
        rel_evt     = 1'b0;
        press_col   = '0;
        press_row   = '0;
        rel_col     = '0;
        rel_row     = '0;
        cur_col     = '0;
        cur_row     = '0;
    endtask

    // Advance the tracker by one accepted word and queue the answer it owes
    task automatic track_word(input t_op op, input logic [RAW_BITS-1:0] rx, ry,
                              input logic [PRESS_BITS-1:0] pz);
        logic [PIXEL_BITS-1:0] col, row, top;
        t_answer ans;
        ans = '0;
        case (op)
            OP_SAMPLE: begin
                if (cal_p_low <= pz && pz <= cal_p_high) begin
                    top = max_index(cal_height);
                    col = map_axis(rx, cal_x_begin, cal_x_end, max_index(cal_width));
                    row = top - map_axis(ry, cal_y_begin, cal_y_end, top);
                    if (cal_y_begin >= cal_y_end) row = '0;
                    if (is_down) begin
                        // held touch drops both events
                        press_evt = 1'b0;
                        rel_evt   = 1'b0;
                    end else begin
                        is_down   = 1'b1;
                        press_evt = 1'b1;
                        press_col = col;
                        press_row = row;
                    end
                    cur_col = col;
                    cur_row = row;
                end else if (is_down) begin
                    is_down = 1'b0;
                    rel_evt = 1'b1;
                    rel_col = press_col;
                    rel_row = press_row;
                end
            end
            OP_TAKE_PRESS: begin
                if (press_evt) begin
                    press_evt = 1'b0;
                    ans = '{found: 1'b1, col: press_col, row: press_row};
                end
            end
            OP_TAKE_RELEASE: begin
                if (rel_evt) begin
                    rel_evt = 1'b0;
                    ans = '{found: 1'b1, col: rel_col, row: rel_row};
                end
            end
            default: begin
                if (is_down) ans = '{found: 1'b1, col: cur_col, row: cur_row};
            end
        endcase
        if (op != OP_SAMPLE) pending_answers.push_back(ans);
    endtask

    // ---------------------------------------------------------------- drivers

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_word(input t_op op, input logic [RAW_BITS-1:0] rx, ry,
                             input logic [PRESS_BITS-1:0] pz);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= IN_DATA_BITS'({pz, ry, rx});
        s_user  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_word(op, rx, ry, pz);
        words_sent++;
    endtask

    // Stop sending and wait until every answer is in and the block has settled
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH:  cal_width   = data[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: cal_height  = data[SIZE_BITS-1:0];
            REG_PRESSURE_LOW:  cal_p_low   = data[PRESS_BITS-1:0];
            REG_PRESSURE_HIGH: cal_p_high  = data[PRESS_BITS-1:0];
            REG_X_BEGIN:       cal_x_begin = data[RAW_BITS-1:0];
            REG_X_END:         cal_x_end   = data[RAW_BITS-1:0];
            REG_Y_BEGIN:       cal_y_begin = data[RAW_BITS-1:0];
            default:           cal_y_end   = data[RAW_BITS-1:0];
        endcase
    endtask

    // Write all eight registers once the block is idle
    task automatic apply_calibration(input logic [CFG_DATA_BITS-1:0] w, h, pl, ph,
                                     xb, xe, yb, ye);
        wait_quiet();
        cfg_put(REG_SCREEN_WIDTH, w);
        cfg_put(REG_SCREEN_HEIGHT, h);
        cfg_put(REG_PRESSURE_LOW, pl);
        cfg_put(REG_PRESSURE_HIGH, ph);
        cfg_put(REG_X_BEGIN, xb);
        cfg_put(REG_X_END, xe);
        cfg_put(REG_Y_BEGIN, yb);
        cfg_put(REG_Y_END, ye);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [RAW_BITS-1:0] pick_raw();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return RAW_BITS'($urandom);
        endcase
    endfunction

    // Pressure that counts as a touch under the current bounds, edges favored
    function automatic logic [PRESS_BITS-1:0] touch_pz();
        if (cal_p_low > cal_p_high) return PRESS_BITS'($urandom);
        case ($urandom_range(7))
            0:       return cal_p_low;
            1:       return cal_p_high;
            default: return PRESS_BITS'($urandom_range(cal_p_high, cal_p_low));
        endcase
    endfunction

    // Pressure outside the bounds, below or above, where one exists
    function automatic logic [PRESS_BITS-1:0] lift_pz();
        if (cal_p_low > cal_p_high) return PRESS_BITS'($urandom);
        if (cal_p_low != 0 && (cal_p_high == '1 || $urandom_range(1) == 0))
            return PRESS_BITS'($urandom_range(32'(cal_p_low) - 1, 0));
        if (cal_p_high != '1)
            return PRESS_BITS'($urandom_range(32'hFFFF, 32'(cal_p_high) + 1));
        return PRESS_BITS'($urandom);
    endfunction

    task automatic send_read();
        send_word(t_op'($urandom_range(OP_READ_POS, OP_TAKE_PRESS)),
                  RAW_BITS'($urandom), RAW_BITS'($urandom), PRESS_BITS'($urandom));
    endtask

    // Press, drag with reads in between, lift, then read the events back
    task automatic gesture();
        int touches;
        touches = $urandom_range(6, 1);
        repeat (touches) begin
            send_word(OP_SAMPLE, pick_raw(), pick_raw(), touch_pz());
            repeat ($urandom_range(2, 0)) send_read();
        end
        send_word(OP_SAMPLE, pick_raw(), pick_raw(), lift_pz());
        repeat ($urandom_range(3, 1)) send_read();
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_size();
        logic [SIZE_BITS-1:0] s;
        case ($urandom_range(9))
            0:       s = '0;
            1:       s = SIZE_BITS'($urandom_range(8191, 4097));
            2:       s = SIZE_BITS'(4096);
            3:       s = SIZE_BITS'(1);
            default: s = SIZE_BITS'($urandom_range(4096, 1));
        endcase
        return {3'($urandom), s};
    endfunction

    // Window as {begin, end}: mostly proper, sometimes empty or crossed
    function automatic logic [2*RAW_BITS-1:0] pick_window();
        logic [RAW_BITS-1:0] a, b;
        a = RAW_BITS'($urandom);
        b = RAW_BITS'($urandom);
        case ($urandom_range(9))
            0:       b = a;
            1:       if (a < b) {a, b} = {b, a};
            default: if (a > b) {a, b} = {b, a};
        endcase
        return {a, b};
    endfunction

    task automatic random_calibration();
        logic [2*RAW_BITS-1:0] xw, yw;
        logic [PRESS_BITS-1:0] pl, ph;
        xw = pick_window();
        yw = pick_window();
        case ($urandom_range(9))
            0: begin
                pl = PRESS_BITS'($urandom_range(32'hFFFF, 1));
                ph = PRESS_BITS'($urandom_range(32'(pl) - 1, 0));
            end
            1: begin
                pl = '0;
                ph = '1;
            end
            default: begin
                pl = PRESS_BITS'($urandom_range(3000, 0));
                ph = PRESS_BITS'($urandom_range(32'hFFFF, 32'(pl)));
            end
        endcase
        apply_calibration(pick_size(), pick_size(), pl, ph,
                          {6'($urandom), xw[2*RAW_BITS-1:RAW_BITS]}, {6'($urandom), xw[RAW_BITS-1:0]},
                          {6'($urandom), yw[2*RAW_BITS-1:RAW_BITS]}, {6'($urandom), yw[RAW_BITS-1:0]});
    endtask

    // ---------------------------------------------------------------- tests

    // Reset calibration: empty reads, bound edges, event life cycle
    task automatic test_defaults_directed();
        send_word(OP_TAKE_PRESS, '0, '0, '0);
        send_word(OP_TAKE_RELEASE, '1, '1, '1);
        send_word(OP_READ_POS, '0, '0, '0);
        send_word(OP_SAMPLE, 10'd500, 10'd500, P_LOW_RST - 16'd1);
        send_word(OP_SAMPLE, 10'd500, 10'd500, P_HIGH_RST + 16'd1);
        send_word(OP_SAMPLE, '0, '0, P_LOW_RST);
        send_word(OP_READ_POS, '1, '1, '1);
        send_word(OP_TAKE_PRESS, '0, '0, '0);
        send_word(OP_TAKE_PRESS, '0, '0, '0);
        send_word(OP_SAMPLE, '1, '1, P_HIGH_RST);
        send_word(OP_READ_POS, '0, '0, '0);
        // lift, then a lift while already up
        send_word(OP_SAMPLE, 10'd300, 10'd300, '0);
        send_word(OP_SAMPLE, 10'd300, 10'd300, '1);
        send_word(OP_READ_POS, '0, '0, '0);
        // new touch with the release still pending
        send_word(OP_SAMPLE, 10'd500, 10'd700, 16'd500);
        send_word(OP_TAKE_RELEASE, '0, '0, '0);
        send_word(OP_TAKE_PRESS, '0, '0, '0);
        send_word(OP_SAMPLE, '0, '0, '0);
        send_word(OP_SAMPLE, 10'd130, 10'd910, 16'd20);
        // held touch drops both pending events
        send_word(OP_SAMPLE, 10'd890, 10'd80, 16'd999);
        send_word(OP_TAKE_RELEASE, '0, '0, '0);
        send_word(OP_TAKE_PRESS, '0, '0, '0);
        send_word(OP_READ_POS, '0, '0, '0);
    endtask

    // Extreme register settings, each followed by a few gestures
    task automatic test_calibration_edges();
        // zero sizes act as one, full windows
        apply_calibration(16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd1023, 16'd0, 16'd1023);
        repeat (3) gesture();
        // largest legal size
        apply_calibration(16'd4096, 16'd4096, 16'd0, 16'hFFFE, 16'd0, 16'd1023, 16'd0, 16'd1023);
        repeat (3) gesture();
        // oversize saturates, one-step windows
        apply_calibration(16'h1FFF, 16'd4097, 16'd100, 16'd100, 16'd1022, 16'd1023, 16'd1022, 16'd1023);
        repeat (3) gesture();
        // empty x window, crossed y window
        apply_calibration(16'd800, 16'd600, 16'd0, 16'd500, 16'd500, 16'd500, 16'd900, 16'd100);
        repeat (3) gesture();
        // size one, junk above the register widths
        apply_calibration(16'hE001, 16'hE001, 16'd5, 16'd60000, 16'hFC00, 16'hFFFF, 16'hFC00, 16'hFFFF);
        repeat (3) gesture();
        // every pressure accepted, nothing lifts
        apply_calibration(16'd320, 16'd240, 16'd0, 16'hFFFF, 16'd50, 16'd950, 16'd50, 16'd950);
        repeat (2) gesture();
        // crossed pressure bounds: no touch at all
        apply_calibration(16'd320, 16'd240, 16'd2000, 16'd1000, 16'd50, 16'd950, 16'd50, 16'd950);
        repeat (2) gesture();
        apply_calibration(CFG_DATA_BITS'(WIDTH_RST), CFG_DATA_BITS'(HEIGHT_RST),
                          CFG_DATA_BITS'(P_LOW_RST), CFG_DATA_BITS'(P_HIGH_RST),
                          CFG_DATA_BITS'(X_BEGIN_RST), CFG_DATA_BITS'(X_END_RST),
                          CFG_DATA_BITS'(Y_BEGIN_RST), CFG_DATA_BITS'(Y_END_RST));
    endtask

    // Hold the receiver off so the output word backs up into the input
    task automatic test_output_backpressure();
        wait_quiet();
        hold_req <= ~hold_req;
        send_word(OP_SAMPLE, pick_raw(), pick_raw(), touch_pz());
        repeat (30) send_read();
        gesture();
        wait_quiet();
    endtask

    // Drain everything in the middle of traffic, then carry on
    task automatic test_sender_pause();
        repeat (4) gesture();
        wait_quiet();
        repeat (4) gesture();
    endtask

    // Random calibrations and gesture-heavy traffic across three idle patterns
    task automatic test_random_traffic();
        int target;
        for (int c = 0; c < 14; c++) begin
            if (c < 5) begin
                snd_idle_pct = 15;
                rcv_idle_pct = 48;
            end else if (c < 10) begin
                snd_idle_pct = 48;
                rcv_idle_pct = 15;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            random_calibration();
            target = words_sent + 75;
            while (words_sent < target) begin
                if ($urandom_range(99) < 80) begin
                    gesture();
                end else begin
                    send_word(t_op'($urandom_range(OP_READ_POS, OP_SAMPLE)),
                              RAW_BITS'($urandom), RAW_BITS'($urandom), PRESS_BITS'($urandom));
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // Check each accepted answer word, then pick the next ready level
    always @(posedge i_clk) begin : rx_side
        t_answer want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_answers.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected answer word: expected none, actual found=%0d col=%0d row=%0d",
                             $time, o_m_axis_tuser, o_m_axis_tdata[PIXEL_BITS-1:0],
                             o_m_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]);
            end else begin
                want = pending_answers.pop_front();
                if (o_m_axis_tuser !== want.found) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: found mismatch: expected %0d, actual %0d",
                                 $time, want.found, o_m_axis_tuser);
                end
                if (o_m_axis_tdata[PIXEL_BITS-1:0] !== want.col) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: x_out mismatch: expected %0d, actual %0d",
                                 $time, want.col, o_m_axis_tdata[PIXEL_BITS-1:0]);
                end
                if (o_m_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS] !== want.row) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: y_out mismatch: expected %0d, actual %0d",
                                 $time, want.row, o_m_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]);
                end
            end
        end
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        reset_tracker();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults_directed();
        test_calibration_edges();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_quiet();
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/tprt_pkg.sv
design/tprt_scale.sv
design/touch_press_release_tracker_unit.sv
verif/tb.sv
